[design/mte_pkg.sv]
`default_nettype none
package mte_pkg;

	// Token kinds carried in the func field.
	typedef enum logic [3:0] {
		FUNC_NIL    = 4'd0,
		FUNC_BOOL   = 4'd1,
		FUNC_SINT   = 4'd2,
		FUNC_UINT   = 4'd3,
		FUNC_ARRAY  = 4'd4,
		FUNC_MAP    = 4'd5,
		FUNC_STR    = 4'd6,
		FUNC_BIN    = 4'd7,
		FUNC_RAW    = 4'd8
	} func_t;

	// Tag bytes.
	localparam logic [7:0] TAG_NIL      = 8'hc0;
	localparam logic [7:0] TAG_FALSE    = 8'hc2;
	localparam logic [7:0] TAG_TRUE     = 8'hc3;
	localparam logic [7:0] TAG_BIN8     = 8'hc4;
	localparam logic [7:0] TAG_BIN16    = 8'hc5;
	localparam logic [7:0] TAG_BIN32    = 8'hc6;
	localparam logic [7:0] TAG_UINT8    = 8'hcc;
	localparam logic [7:0] TAG_UINT16   = 8'hcd;
	localparam logic [7:0] TAG_UINT32   = 8'hce;
	localparam logic [7:0] TAG_UINT64   = 8'hcf;
	localparam logic [7:0] TAG_INT8     = 8'hd0;
	localparam logic [7:0] TAG_INT16    = 8'hd1;
	localparam logic [7:0] TAG_INT32    = 8'hd2;
	localparam logic [7:0] TAG_INT64    = 8'hd3;
	localparam logic [7:0] TAG_STR8     = 8'hd9;
	localparam logic [7:0] TAG_STR16    = 8'hda;
	localparam logic [7:0] TAG_STR32    = 8'hdb;
	localparam logic [7:0] TAG_ARRAY16  = 8'hdc;
	localparam logic [7:0] TAG_ARRAY32  = 8'hdd;
	localparam logic [7:0] TAG_MAP16    = 8'hde;
	localparam logic [7:0] TAG_MAP32    = 8'hdf;
	localparam logic [7:0] TAG_FIXARRAY = 8'h90;
	localparam logic [7:0] TAG_FIXMAP   = 8'h80;
	localparam logic [7:0] TAG_FIXSTR   = 8'ha0;

	// Command queue geometry; the depth must be a power of two.
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic [3:0]  func;
		logic [63:0] value;
	} tok_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} enc_t;

	// One classified token: tag byte, number of payload bytes (0..8) and the
	// payload left-aligned so that its first byte sits in bits 63:56.
	typedef struct packed {
		logic [7:0]  tag;
		logic [3:0]  nbytes;
		logic [63:0] payload;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

endpackage
`default_nettype wire

[design/mte_front.sv]
`default_nettype none
module mte_front import mte_pkg::*; (
	input  wire  logic tok_valid,
	output logic       tok_stall,
	input  wire  tok_t tok_data,
	input  wire  logic q_full,
	output logic       push,
	output cmd_t       cmd
);

	logic [63:0] v;
	logic [31:0] lo;
	logic        known;
	logic [7:0]  tag;
	logic [3:0]  nb;

	assign v  = tok_data.value;
	assign lo = tok_data.value[31:0];

	always_comb begin
		known = 1'b1;
		tag   = TAG_NIL;
		nb    = 4'd0;
		unique case (tok_data.func)
			FUNC_NIL: begin
				tag = TAG_NIL;
			end
			FUNC_BOOL: begin
				tag = (v != 64'd0) ? TAG_TRUE : TAG_FALSE;
			end
			FUNC_SINT: begin
				if (v[63:7] == 57'd0 || (&v[63:5])) begin
					tag = v[7:0];
				end else if (&v[63:7]) begin
					tag = TAG_INT8;
					nb  = 4'd1;
				end else if (v[63:15] == 49'd0 || (&v[63:15])) begin
					tag = TAG_INT16;
					nb  = 4'd2;
				end else if (v[63:31] == 33'd0 || (&v[63:31])) begin
					tag = TAG_INT32;
					nb  = 4'd4;
				end else begin
					tag = TAG_INT64;
					nb  = 4'd8;
				end
			end
			FUNC_UINT: begin
				if (v[63:8] == 56'd0) begin
					tag = TAG_UINT8;
					nb  = 4'd1;
				end else if (v[63:16] == 48'd0) begin
					tag = TAG_UINT16;
					nb  = 4'd2;
				end else if (v[63:32] == 32'd0) begin
					tag = TAG_UINT32;
					nb  = 4'd4;
				end else begin
					tag = TAG_UINT64;
					nb  = 4'd8;
				end
			end
			FUNC_ARRAY, FUNC_MAP: begin
				if (lo[31:4] == 28'd0) begin
					tag = ((tok_data.func == FUNC_ARRAY) ? TAG_FIXARRAY : TAG_FIXMAP)
						| {4'd0, lo[3:0]};
				end else if (lo[31:16] == 16'd0) begin
					tag = (tok_data.func == FUNC_ARRAY) ? TAG_ARRAY16 : TAG_MAP16;
					nb  = 4'd2;
				end else begin
					tag = (tok_data.func == FUNC_ARRAY) ? TAG_ARRAY32 : TAG_MAP32;
					nb  = 4'd4;
				end
			end
			FUNC_STR: begin
				if (lo[31:5] == 27'd0) begin
					tag = TAG_FIXSTR | {3'd0, lo[4:0]};
				end else if (lo[31:8] == 24'd0) begin
					tag = TAG_STR8;
					nb  = 4'd1;
				end else if (lo[31:16] == 16'd0) begin
					tag = TAG_STR16;
					nb  = 4'd2;
				end else begin
					tag = TAG_STR32;
					nb  = 4'd4;
				end
			end
			FUNC_BIN: begin
				if (lo[31:8] == 24'd0) begin
					tag = TAG_BIN8;
					nb  = 4'd1;
				end else if (lo[31:16] == 16'd0) begin
					tag = TAG_BIN16;
					nb  = 4'd2;
				end else begin
					tag = TAG_BIN32;
					nb  = 4'd4;
				end
			end
			FUNC_RAW: begin
				tag = v[7:0];
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	// Left-align the payload bytes for the serializer.
	always_comb begin
		cmd.tag    = tag;
		cmd.nbytes = nb;
		case (nb)
			4'd1:    cmd.payload = {v[7:0], 56'd0};
			4'd2:    cmd.payload = {v[15:0], 48'd0};
			4'd4:    cmd.payload = {v[31:0], 32'd0};
			default: cmd.payload = v;
		endcase
	end

	assign tok_stall = q_full;
	// Undefined token kinds are taken and dropped.
	assign push      = tok_valid && !q_full && known;

endmodule
`default_nettype wire

[design/mte_queue.sv]
`default_nettype none
module mte_queue import mte_pkg::*; (
	input  wire  logic   clk,
	input  wire  logic   arst_n,
	input  wire  logic   push,
	input  wire  cmd_t   wr_cmd,
	input  wire  logic   pop,
	output cmd_t         rd_cmd,
	output qstat_t       stat
);

	cmd_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rd_cmd     = mem_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == (QAW+1)'(QDEPTH));

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && stat.full)) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && stat.empty)) else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QAW+1)'(QDEPTH)) else $error("queue count out of range");

endmodule
`default_nettype wire

[design/mte_back.sv]
`default_nettype none
module mte_back import mte_pkg::*; (
	input  wire  logic   clk,
	input  wire  logic   arst_n,
	input  wire  cmd_t   cmd,
	input  wire  qstat_t stat,
	output logic         pop,
	output logic         enc_valid,
	input  wire  logic   enc_stall,
	output enc_t         enc_data
);

	logic        out_valid_q;
	enc_t        out_q;
	logic [63:0] shift_q;
	logic [3:0]  rem_q;
	logic        advance;

	assign advance = !out_valid_q || !enc_stall;
	assign pop     = advance && (rem_q == 4'd0) && !stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rem_q       <= 4'd0;
		end else if (advance) begin
			if (rem_q != 4'd0) begin
				out_valid_q <= 1'b1;
				rem_q       <= rem_q - 4'd1;
			end else if (!stat.empty) begin
				out_valid_q <= 1'b1;
				rem_q       <= cmd.nbytes;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (rem_q != 4'd0) begin
				out_q.out_byte <= shift_q[63:56];
				out_q.last     <= (rem_q == 4'd1);
				shift_q        <= {shift_q[55:0], 8'd0};
			end else if (!stat.empty) begin
				out_q.out_byte <= cmd.tag;
				out_q.last     <= (cmd.nbytes == 4'd0);
				shift_q        <= cmd.payload;
			end
		end
	end

	assign enc_valid = out_valid_q;
	assign enc_data  = out_q;

	a_busy_shows_beat: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q != 4'd0 |-> out_valid_q) else $error("payload pending without a beat");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= 4'd8) else $error("byte count out of range");
	a_last_ends_token: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rem_q != 4'd0 |-> !out_q.last)
		else $error("last set while payload bytes remain");

endmodule
`default_nettype wire

[design/msgpack_token_encoder.sv]
`default_nettype none
// MessagePack token encoder. Each beat on the tok channel carries one token
// (nil, bool, signed or unsigned integer, array/map/str/bin header, or one raw
// payload byte), and the enc channel returns its encoding one byte per beat,
// tag byte first and then the payload big-endian, with last set on the final
// byte. A token yields 1 to 9 beats; undefined token kinds are accepted and
// produce none. The front end classifies a token in the cycle it arrives and
// writes it into a four-entry command queue, so tokens keep being taken while
// the serializer is still shifting out an earlier one. While the output is not
// stalled, the serializer emits one byte per cycle from its output register,
// so throughput is set by the byte-wide output, and tokens waiting in the queue
// follow each other without a gap. An accepted token is registered in the
// command queue and then in the serializer's output register before its first
// output beat appears.
module msgpack_token_encoder import mte_pkg::*; (
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic tok_valid,
	output logic       tok_stall,
	input  wire  tok_t tok_data,
	output logic       enc_valid,
	input  wire  logic enc_stall,
	output enc_t       enc_data
);

	// Classified command from the front end into the queue.
	logic   push;
	cmd_t   wr_cmd;
	// Head of the queue and its status, seen by the serializer.
	cmd_t   rd_cmd;
	qstat_t stat;
	logic   pop;

	mte_front u_front (
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_data  (tok_data),
		.q_full    (stat.full),
		.push      (push),
		.cmd       (wr_cmd)
	);

	mte_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.rd_cmd (rd_cmd),
		.stat   (stat)
	);

	// The serializer pops a command when it is about to show the tag byte and
	// then shifts the left-aligned payload out one byte per accepted beat.
	mte_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (rd_cmd),
		.stat      (stat),
		.pop       (pop),
		.enc_valid (enc_valid),
		.enc_stall (enc_stall),
		.enc_data  (enc_data)
	);

endmodule
`default_nettype wire

[tb/encoder_checker.sv]
// Watches both channels of the token encoder, predicts the byte stream of
// every accepted token and compares it with the encoder's output beats.
module encoder_checker import mte_pkg::*; (
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic tok_valid,
	input  wire  logic tok_stall,
	input  wire  tok_t tok_data,
	input  wire  logic enc_valid,
	input  wire  logic enc_stall,
	input  wire  enc_t enc_data,
	output int         mismatch_count,
	output int         pending_bytes
);

	enc_t expected_bytes[$];

	initial begin
		mismatch_count = 0;
		pending_bytes = 0;
	end

	// Classifies one token into its tag, payload length and payload value, then
	// queues the tag followed by the payload bytes, most significant first.
	task automatic queue_encoding(input tok_t tok);
		logic [7:0]  tag;
		logic [63:0] v;
		logic [63:0] low32;
		int          n;
		bit          emits;
		tag = 8'h00;
		v = tok.value;
		low32 = {32'd0, tok.value[31:0]};
		n = 0;
		emits = 1'b1;
		case (tok.func)
			FUNC_NIL: begin
				tag = TAG_NIL;
			end
			FUNC_BOOL: begin
				tag = (v != 64'd0) ? TAG_TRUE : TAG_FALSE;
			end
			FUNC_SINT: begin
				if (v < 64'd128 || v >= 64'hffff_ffff_ffff_ffe0) begin
					tag = v[7:0];
				end else if (v >= 64'hffff_ffff_ffff_ff80) begin
					tag = TAG_INT8;
					n = 1;
				end else if (v + 64'h8000 <= 64'hffff) begin
					tag = TAG_INT16;
					n = 2;
				end else if (v + 64'h8000_0000 <= 64'hffff_ffff) begin
					tag = TAG_INT32;
					n = 4;
				end else begin
					tag = TAG_INT64;
					n = 8;
				end
			end
			FUNC_UINT: begin
				if (v <= 64'hff) begin
					tag = TAG_UINT8;
					n = 1;
				end else if (v <= 64'hffff) begin
					tag = TAG_UINT16;
					n = 2;
				end else if (v <= 64'hffff_ffff) begin
					tag = TAG_UINT32;
					n = 4;
				end else begin
					tag = TAG_UINT64;
					n = 8;
				end
			end
			FUNC_ARRAY, FUNC_MAP: begin
				v = low32;
				if (v < 64'd16) begin
					tag = ((tok.func == FUNC_ARRAY) ? TAG_FIXARRAY : TAG_FIXMAP) | v[7:0];
				end else if (v <= 64'hffff) begin
					tag = (tok.func == FUNC_ARRAY) ? TAG_ARRAY16 : TAG_MAP16;
					n = 2;
				end else begin
					tag = (tok.func == FUNC_ARRAY) ? TAG_ARRAY32 : TAG_MAP32;
					n = 4;
				end
			end
			FUNC_STR: begin
				v = low32;
				if (v < 64'd32) begin
					tag = TAG_FIXSTR | v[7:0];
				end else if (v < 64'd256) begin
					tag = TAG_STR8;
					n = 1;
				end else if (v < 64'd65536) begin
					tag = TAG_STR16;
					n = 2;
				end else begin
					tag = TAG_STR32;
					n = 4;
				end
			end
			FUNC_BIN: begin
				v = low32;
				if (v <= 64'hff) begin
					tag = TAG_BIN8;
					n = 1;
				end else if (v <= 64'hffff) begin
					tag = TAG_BIN16;
					n = 2;
				end else begin
					tag = TAG_BIN32;
					n = 4;
				end
			end
			FUNC_RAW: begin
				tag = v[7:0];
			end
			default: begin
				emits = 1'b0;
			end
		endcase
		if (emits) begin
			expected_bytes.push_back('{out_byte: tag, last: (n == 0)});
			for (int k = 0; k < n; k++) begin
				expected_bytes.push_back('{out_byte: 8'(v >> (8 * (n - 1 - k))),
					last: (k == n - 1)});
			end
		end
	endtask

	// The output beat is checked before the token of the same edge is queued,
	// so a spurious beat can never be matched against a token just taken.
	always @(posedge clk) begin
		enc_t want;
		if (arst_n) begin
			if (enc_valid && !enc_stall) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected output beat: out_byte %h last %b",
						enc_data.out_byte, enc_data.last);
					mismatch_count++;
				end else begin
					want = expected_bytes.pop_front();
					if (enc_data.out_byte !== want.out_byte) begin
						$error("out_byte: expected %h, actual %h", want.out_byte,
							enc_data.out_byte);
						mismatch_count++;
					end
					if (enc_data.last !== want.last) begin
						$error("last: expected %b, actual %b", want.last, enc_data.last);
						mismatch_count++;
					end
				end
			end
			if (tok_valid && !tok_stall) begin
				queue_encoding(tok_data);
			end
			pending_bytes = expected_bytes.size();
		end
	end

endmodule

[tb/testbench.sv]
// Top of the token encoder testbench. It drives tokens into the encoder,
// randomly stalls the byte output, and leaves all prediction and comparison
// to the checker instantiated beside the encoder.
module testbench;
	import mte_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic tok_valid;
	logic tok_stall;
	tok_t tok_data;
	logic enc_valid;
	logic enc_stall;
	enc_t enc_data;
	int   mismatch_count;
	int   pending_bytes;

	// When calm is set, neither side idles, so tokens run back to back.
	bit   calm;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	msgpack_token_encoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_data  (tok_data),
		.enc_valid (enc_valid),
		.enc_stall (enc_stall),
		.enc_data  (enc_data)
	);

	encoder_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.tok_valid      (tok_valid),
		.tok_stall      (tok_stall),
		.tok_data       (tok_data),
		.enc_valid      (enc_valid),
		.enc_stall      (enc_stall),
		.enc_data       (enc_data),
		.mismatch_count (mismatch_count),
		.pending_bytes  (pending_bytes)
	);

	// Idle lengths: mostly none, often short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Operands are biased toward the edges of the encoding forms: small
	// magnitudes, powers of two plus or minus a little, and their negatives,
	// with fully random words mixed in so that every bit toggles.
	function automatic logic [63:0] pick_operand();
		logic [63:0] v;
		int          k;
		k = $urandom_range(1, 63);
		case ($urandom_range(0, 5))
			0: v = 64'($urandom_range(0, 300));
			1: v = (64'd1 << k) + 64'($signed($urandom_range(0, 6)) - 3);
			2: v = -((64'd1 << k) + 64'($signed($urandom_range(0, 6)) - 3));
			3: v = {$urandom, $urandom};
			4: v = {$urandom, $urandom} >> $urandom_range(0, 63);
			default: v = -64'($urandom_range(0, 300));
		endcase
		return v;
	endfunction

	// Entered and left at a falling edge. The beat is held until the encoder
	// takes it; valid only drops when an idle gap follows.
	task automatic send_token(input logic [3:0] func, input logic [63:0] value);
		int gap;
		tok_data <= '{func: func, value: value};
		tok_valid <= 1'b1;
		do @(posedge clk); while (tok_stall !== 1'b0);
		gap = calm ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			tok_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Output stall: random stretches held for random lengths, none while calm.
	initial begin
		int hold;
		enc_stall = 1'b0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (calm) begin
				enc_stall <= 1'b0;
				hold = 0;
			end else if (hold > 0) begin
				hold--;
			end else begin
				enc_stall <= ($urandom_range(0, 2) == 0);
				hold = pick_gap();
			end
		end
	end

	initial begin
		int          sent;
		logic [3:0]  func;
		logic [63:0] value;
		arst_n = 1'b0;
		tok_valid = 1'b0;
		tok_data = '0;
		calm = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: every token kind at the borders between its forms.
		send_token(FUNC_NIL, 64'd0);
		send_token(FUNC_BOOL, 64'd0);
		send_token(FUNC_BOOL, 64'h8000_0000_0000_0000);
		send_token(FUNC_SINT, 64'd127);
		send_token(FUNC_SINT, -64'd32);
		send_token(FUNC_SINT, -64'd33);
		send_token(FUNC_SINT, 64'd128);
		send_token(FUNC_SINT, -64'd32769);
		send_token(FUNC_SINT, 64'h0000_0000_8000_0000);
		send_token(FUNC_SINT, 64'h8000_0000_0000_0000);
		send_token(FUNC_UINT, 64'd0);
		send_token(FUNC_UINT, 64'd256);
		send_token(FUNC_UINT, 64'h1_0000);
		send_token(FUNC_UINT, 64'hffff_ffff_ffff_ffff);
		send_token(FUNC_ARRAY, 64'd15);
		// Only the low word of a header operand counts.
		send_token(FUNC_ARRAY, 64'hffff_ffff_0001_0000);
		send_token(FUNC_MAP, 64'd16);
		send_token(FUNC_MAP, 64'hffff);
		send_token(FUNC_STR, 64'd31);
		send_token(FUNC_STR, 64'd32);
		send_token(FUNC_STR, 64'h1_0000);
		send_token(FUNC_BIN, 64'd0);
		send_token(FUNC_BIN, 64'h1_0000_0000);
		send_token(FUNC_RAW, 64'hffff_ffff_ffff_ffff);
		// Undefined token kinds are taken but produce no bytes.
		send_token(4'd9, 64'hffff_ffff_ffff_ffff);
		send_token(4'd15, 64'd0);

		// Random part. Undefined kinds are mixed in but not counted.
		sent = 0;
		while (sent < 500) begin
			if ($urandom_range(0, 99) < 4) begin
				func = 4'($urandom_range(9, 15));
			end else begin
				func = 4'($urandom_range(0, 8));
				sent++;
			end
			value = pick_operand();
			calm = (sent >= 300 && sent < 360);
			send_token(func, value);
			// Once mid-run, the sender holds off until the encoder has drained.
			if (sent == 200 && func <= FUNC_RAW) begin
				tok_valid <= 1'b0;
				while (pending_bytes != 0) @(negedge clk);
			end
		end
		tok_valid <= 1'b0;

		// Let the last bytes drain, then give any stray beat time to show up
		// before the verdict.
		wait (pending_bytes == 0);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_bytes == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("testbench failed");
		$finish;
	end

endmodule
